FILE: rtl/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg
// Token kinds, status codes and the result record of the assembly token lexer.
// ----------------------------------------------------------------------------
package atl_pkg;

    localparam logic [4:0] KIND_R0        = 5'd0;
    localparam logic [4:0] KIND_IMM       = 5'd4;
    localparam logic [4:0] KIND_ADD       = 5'd5;
    localparam logic [4:0] KIND_ADDI      = 5'd6;
    localparam logic [4:0] KIND_AND       = 5'd7;
    localparam logic [4:0] KIND_SUB       = 5'd8;
    localparam logic [4:0] KIND_SHIFT     = 5'd9;
    localparam logic [4:0] KIND_STORE     = 5'd10;
    localparam logic [4:0] KIND_XOR       = 5'd11;
    localparam logic [4:0] KIND_OR        = 5'd12;
    localparam logic [4:0] KIND_ORI       = 5'd13;
    localparam logic [4:0] KIND_ORHI      = 5'd14;
    localparam logic [4:0] KIND_LOAD      = 5'd15;
    localparam logic [4:0] KIND_BLT       = 5'd16;
    localparam logic [4:0] KIND_BE        = 5'd17;
    localparam logic [4:0] KIND_IMMEDIATE = 5'd18;

    localparam logic [1:0] STATUS_TOKEN    = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_BAD_END  = 2'd2;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] value;
        logic [1:0]  status;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } result_t;

endpackage

FILE: rtl/assembly_token_lexer_top.sv
// ----------------------------------------------------------------------------
// assembly_token_lexer_top
// Byte-stream lexer for a small assembly language.
// ----------------------------------------------------------------------------
// The lexer takes one source byte per ready cycle: each transfer is decoded
// in the cycle it is accepted, and its results are written into a four-entry
// output queue that drains one result per m_ready cycle, the first one valid
// the cycle after the byte. A byte that closes a pending ADD, OR or immediate
// and is itself illegal yields two results; ready drops only while the queue
// holds more than two results, so a stalled consumer costs the producer
// nothing until three results are waiting. Errors are reported once with line
// and column, and later bytes are ignored until an end-of-input transfer.
// ----------------------------------------------------------------------------
module assembly_token_lexer_top #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_token_kind,
    output logic [15:0] m_value,
    output logic [1:0]  m_status,
    output logic [15:0] m_err_line,
    output logic [15:0] m_err_column,
    output logic        m_last
);
    import atl_pkg::*;

    localparam int W          = VALUE_WIDTH;
    localparam int DEPTH      = 4;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_R    = 5'd1;
    localparam logic [4:0] ST_I    = 5'd2;
    localparam logic [4:0] ST_IM   = 5'd3;
    localparam logic [4:0] ST_A    = 5'd4;
    localparam logic [4:0] ST_AD   = 5'd5;
    localparam logic [4:0] ST_ADD  = 5'd6;
    localparam logic [4:0] ST_AN   = 5'd7;
    localparam logic [4:0] ST_S    = 5'd8;
    localparam logic [4:0] ST_SU   = 5'd9;
    localparam logic [4:0] ST_SH   = 5'd10;
    localparam logic [4:0] ST_SHI  = 5'd11;
    localparam logic [4:0] ST_SHIF = 5'd12;
    localparam logic [4:0] ST_ST   = 5'd13;
    localparam logic [4:0] ST_STO  = 5'd14;
    localparam logic [4:0] ST_STOR = 5'd15;
    localparam logic [4:0] ST_X    = 5'd16;
    localparam logic [4:0] ST_XO   = 5'd17;
    localparam logic [4:0] ST_O    = 5'd18;
    localparam logic [4:0] ST_OR   = 5'd19;
    localparam logic [4:0] ST_ORH  = 5'd20;
    localparam logic [4:0] ST_L    = 5'd21;
    localparam logic [4:0] ST_LO   = 5'd22;
    localparam logic [4:0] ST_LOA  = 5'd23;
    localparam logic [4:0] ST_B    = 5'd24;
    localparam logic [4:0] ST_BL   = 5'd25;
    localparam logic [4:0] ST_ZERO = 5'd26;
    localparam logic [4:0] ST_BIN  = 5'd27;
    localparam logic [4:0] ST_DEC  = 5'd28;
    localparam logic [4:0] ST_HEX  = 5'd29;

    logic [4:0]       state_reg, state_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [15:0]      line_reg, line_next;
    logic [15:0]      col_reg, col_next;
    logic             err_reg, err_next;

    result_t          fifo_mem [DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic             s_fire, m_fire;
    logic [7:0]       c_up;
    logic [15:0]      line_upd, col_upd;
    logic [W+15:0]    acc_ext;
    logic [15:0]      acc16;
    logic [4:0]       digit;
    logic [W-1:0]     acc_bin, acc_dec, acc_hex;
    logic [5:0]       idle_first, idle_redo;
    logic             redo;
    result_t          r0, r1;
    logic             r0_valid, r1_valid;

    // {accepted, next state} for a byte seen between tokens
    function automatic logic [5:0] idle_decode(input logic [7:0] c);
        logic [5:0] res;
        case (c)
            " ", 8'h09, 8'h0A, 8'h0D: res = {1'b1, ST_IDLE};
            "R": res = {1'b1, ST_R};
            "I": res = {1'b1, ST_I};
            "A": res = {1'b1, ST_A};
            "S": res = {1'b1, ST_S};
            "X": res = {1'b1, ST_X};
            "O": res = {1'b1, ST_O};
            "L": res = {1'b1, ST_L};
            "B": res = {1'b1, ST_B};
            "0": res = {1'b1, ST_ZERO};
            default: res = {1'b0, ST_IDLE};
        endcase
        return res;
    endfunction

    function automatic result_t tok(input logic [4:0] kind, input logic [15:0] value);
        result_t r;
        r        = '0;
        r.kind   = kind;
        r.value  = value;
        r.status = STATUS_TOKEN;
        return r;
    endfunction

    function automatic result_t err(input logic [1:0] status, input logic [15:0] line,
                                    input logic [15:0] column);
        result_t r;
        r        = '0;
        r.status = status;
        r.line   = line;
        r.column = column;
        return r;
    endfunction

    assign s_ready = (count_reg <= CNT_W'(DEPTH - 2));
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (count_reg != '0);
    assign m_fire  = m_valid && m_ready;

    assign c_up     = (s_ch >= "a" && s_ch <= "z") ? s_ch - 8'd32 : s_ch;
    assign line_upd = (c_up == 8'h0A && line_reg != 16'hFFFF) ? line_reg + 16'd1 : line_reg;
    assign col_upd  = (c_up == 8'h0A) ? 16'd0 :
                      (col_reg != 16'hFFFF) ? col_reg + 16'd1 : col_reg;

    assign acc_ext = {16'd0, acc_reg};
    assign acc16   = acc_ext[15:0];

    always_comb begin
        digit = 5'd16;
        if (state_reg == ST_BIN && (c_up == "0" || c_up == "1")) begin
            digit = {4'd0, c_up[0]};
        end else if (state_reg != ST_BIN && c_up >= "0" && c_up <= "9") begin
            digit = {1'b0, c_up[3:0]};
        end else if (state_reg == ST_HEX && c_up >= "A" && c_up <= "F") begin
            digit = 5'(c_up - "A" + 8'd10);
        end
    end

    assign acc_bin = {acc_reg[W-2:0], digit[0]};
    assign acc_hex = {acc_reg[W-5:0], digit[3:0]};
    assign acc_dec = {acc_reg[W-4:0], 3'b000} + {acc_reg[W-2:0], 1'b0}
                   + {{(W-4){1'b0}}, digit[3:0]};

    assign idle_first = idle_decode(c_up);
    assign idle_redo  = idle_first;

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        err_next   = err_reg;
        r0         = '0;
        r1         = '0;
        r0_valid   = 1'b0;
        r1_valid   = 1'b0;
        redo       = 1'b0;
        if (s_fire) begin
            if (s_end_of_input) begin
                if (!err_reg) begin
                    r0_valid = 1'b1;
                    case (state_reg)
                        ST_IDLE:                r0_valid = 1'b0;
                        ST_ADD:                 r0 = tok(KIND_ADD, 16'd0);
                        ST_OR:                  r0 = tok(KIND_OR, 16'd0);
                        ST_ZERO:                r0 = tok(KIND_IMMEDIATE, 16'd0);
                        ST_BIN, ST_DEC, ST_HEX: r0 = tok(KIND_IMMEDIATE, acc16);
                        default:                r0 = err(STATUS_BAD_END, line_reg, col_reg);
                    endcase
                end
                state_next = ST_IDLE;
                acc_next   = '0;
                line_next  = 16'd1;
                col_next   = 16'd0;
                err_next   = 1'b0;
            end else if (!err_reg) begin
                line_next = line_upd;
                col_next  = col_upd;
                r0_valid  = 1'b1;
                r0        = err(STATUS_BAD_CHAR, line_upd, col_upd);
                state_next = ST_IDLE;
                case (state_reg)
                    ST_R: if (c_up >= "0" && c_up <= "3")
                        r0 = tok(KIND_R0 + 5'(c_up[1:0]), 16'd0);
                    ST_I: if (c_up == "M") begin
                        state_next = ST_IM; r0_valid = 1'b0;
                    end
                    ST_IM: if (c_up == "M") r0 = tok(KIND_IMM, 16'd0);
                    ST_A: if (c_up == "D") begin
                        state_next = ST_AD; r0_valid = 1'b0;
                    end else if (c_up == "N") begin
                        state_next = ST_AN; r0_valid = 1'b0;
                    end
                    ST_AD: if (c_up == "D") begin
                        state_next = ST_ADD; r0_valid = 1'b0;
                    end
                    ST_ADD: if (c_up == "I") begin
                        r0 = tok(KIND_ADDI, 16'd0);
                    end else begin
                        r0 = tok(KIND_ADD, 16'd0); redo = 1'b1;
                    end
                    ST_AN: if (c_up == "D") r0 = tok(KIND_AND, 16'd0);
                    ST_S: if (c_up == "U") begin
                        state_next = ST_SU; r0_valid = 1'b0;
                    end else if (c_up == "H") begin
                        state_next = ST_SH; r0_valid = 1'b0;
                    end else if (c_up == "T") begin
                        state_next = ST_ST; r0_valid = 1'b0;
                    end
                    ST_SU: if (c_up == "B") r0 = tok(KIND_SUB, 16'd0);
                    ST_SH: if (c_up == "I") begin
                        state_next = ST_SHI; r0_valid = 1'b0;
                    end
                    ST_SHI: if (c_up == "F") begin
                        state_next = ST_SHIF; r0_valid = 1'b0;
                    end
                    ST_SHIF: if (c_up == "T") r0 = tok(KIND_SHIFT, 16'd0);
                    ST_ST: if (c_up == "O") begin
                        state_next = ST_STO; r0_valid = 1'b0;
                    end
                    ST_STO: if (c_up == "R") begin
                        state_next = ST_STOR; r0_valid = 1'b0;
                    end
                    ST_STOR: if (c_up == "E") r0 = tok(KIND_STORE, 16'd0);
                    ST_X: if (c_up == "O") begin
                        state_next = ST_XO; r0_valid = 1'b0;
                    end
                    ST_XO: if (c_up == "R") r0 = tok(KIND_XOR, 16'd0);
                    ST_O: if (c_up == "R") begin
                        state_next = ST_OR; r0_valid = 1'b0;
                    end
                    ST_OR: if (c_up == "I") begin
                        r0 = tok(KIND_ORI, 16'd0);
                    end else if (c_up == "H") begin
                        state_next = ST_ORH; r0_valid = 1'b0;
                    end else begin
                        r0 = tok(KIND_OR, 16'd0); redo = 1'b1;
                    end
                    ST_ORH: if (c_up == "I") r0 = tok(KIND_ORHI, 16'd0);
                    ST_L: if (c_up == "O") begin
                        state_next = ST_LO; r0_valid = 1'b0;
                    end
                    ST_LO: if (c_up == "A") begin
                        state_next = ST_LOA; r0_valid = 1'b0;
                    end
                    ST_LOA: if (c_up == "D") r0 = tok(KIND_LOAD, 16'd0);
                    ST_B: if (c_up == "L") begin
                        state_next = ST_BL; r0_valid = 1'b0;
                    end else if (c_up == "E") begin
                        r0 = tok(KIND_BE, 16'd0);
                    end
                    ST_BL: if (c_up == "T") r0 = tok(KIND_BLT, 16'd0);
                    ST_ZERO: begin
                        acc_next = '0;
                        if (c_up == "B") begin
                            state_next = ST_BIN; r0_valid = 1'b0;
                        end else if (c_up == "D") begin
                            state_next = ST_DEC; r0_valid = 1'b0;
                        end else if (c_up == "X") begin
                            state_next = ST_HEX; r0_valid = 1'b0;
                        end else begin
                            r0 = tok(KIND_IMMEDIATE, 16'd0); redo = 1'b1;
                        end
                    end
                    ST_BIN, ST_DEC, ST_HEX: begin
                        if (digit != 5'd16) begin
                            state_next = state_reg;
                            r0_valid   = 1'b0;
                            case (state_reg)
                                ST_BIN:  acc_next = acc_bin;
                                ST_DEC:  acc_next = acc_dec;
                                default: acc_next = acc_hex;
                            endcase
                        end else begin
                            r0 = tok(KIND_IMMEDIATE, acc16); redo = 1'b1;
                        end
                    end
                    default: begin
                        // between tokens; unknown codes decode the same way
                        if (idle_first[5]) begin
                            state_next = idle_first[4:0];
                            r0_valid   = 1'b0;
                            if (idle_first[4:0] == ST_ZERO) acc_next = '0;
                        end
                    end
                endcase
                if (r0_valid && r0.status == STATUS_BAD_CHAR) err_next = 1'b1;
                if (redo) begin
                    if (idle_redo[5]) begin
                        state_next = idle_redo[4:0];
                        if (idle_redo[4:0] == ST_ZERO) acc_next = '0;
                    end else begin
                        r1_valid   = 1'b1;
                        r1         = err(STATUS_BAD_CHAR, line_upd, col_upd);
                        err_next   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
        end
        r0.last = !r1_valid;
        r1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            acc_reg    <= '0;
            line_reg   <= 16'd1;
            col_reg    <= 16'd0;
            err_reg    <= 1'b0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            err_reg    <= err_next;
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(r0_valid) + PTR_W'(r1_valid);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(m_fire);
            count_reg  <= count_reg + CNT_W'(r0_valid) + CNT_W'(r1_valid) - CNT_W'(m_fire);
        end
    end

    always_ff @(posedge aclk) begin
        if (r0_valid) fifo_mem[wr_ptr_reg] <= r0;
        if (r1_valid) fifo_mem[wr_ptr_reg + PTR_W'(1)] <= r1;
    end

    assign m_token_kind = fifo_mem[rd_ptr_reg].kind;
    assign m_value      = fifo_mem[rd_ptr_reg].value;
    assign m_status     = fifo_mem[rd_ptr_reg].status;
    assign m_err_line   = fifo_mem[rd_ptr_reg].line;
    assign m_err_column = fifo_mem[rd_ptr_reg].column;
    assign m_last       = fifo_mem[rd_ptr_reg].last;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("output queue overflow");

    a_latched_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_end_of_input && err_reg) |=> (count_reg <= $past(count_reg)))
        else $error("result pushed while error latched");

    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_end_of_input) |=>
            (state_reg == ST_IDLE && line_reg == 16'd1 && col_reg == 16'd0 && !err_reg))
        else $error("end of input did not reset the lexer");

    a_err_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STATUS_TOKEN) |-> (m_err_line != 16'd0 && m_token_kind == 5'd0))
        else $error("error result without position");

    a_second_is_error: assert property (@(posedge aclk) disable iff (!aresetn)
        r1_valid |-> (r0_valid && r0.status == STATUS_TOKEN))
        else $error("second result without a closed token");

endmodule
